[design/ucd_pkg.sv]
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types, constants and helper functions for the seconds-to-date core.
// ----------------------------------------------------------------------------
package ucd_pkg;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // Reciprocals for the divisions by constants. x / 86400 is taken as
  // (x >> 7) / 675, t / 3600 as (t >> 4) / 225 and r / 60 as (r >> 2) / 15;
  // each quotient is the high part of the product and is exact over the
  // full range of its operand.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  localparam logic [6:0]  BASE_MOD100   = 7'd70;
  localparam logic [8:0]  BASE_MOD400   = 9'd370;
  localparam logic [11:0] LAST_YEAR     = 12'd2106;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DAY,
    OP_TOD,
    OP_HOUR,
    OP_HOUR_REM,
    OP_MIN,
    OP_MIN_REM,
    OP_YEAR,
    OP_MONTH,
    OP_PUBLISH
  } ucd_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY,
    S_TOD,
    S_HOUR,
    S_HOUR_REM,
    S_MIN,
    S_MIN_REM,
    S_YEAR,
    S_MONTH,
    S_DONE
  } ucd_state_t;

  typedef struct packed {
    ucd_op_t op;
  } ucd_cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } ucd_stat_t;

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR,
      MONTH_JUN,
      MONTH_SEP,
      MONTH_NOV: len = 5'd30;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[design/ucd_datapath.sv]
// ----------------------------------------------------------------------------
// ucd_datapath
// Divisions by constants, year and month walk registers, output registers.
// ----------------------------------------------------------------------------
module ucd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ucd_pkg::ucd_cmd_t cmd,
  output ucd_pkg::ucd_stat_t stat,
  input  logic [31:0]       epoch_seconds,
  output logic [11:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second
);

  logic [31:0] secs;
  logic [15:0] days;
  logic [16:0] tod;
  logic [4:0]  hour_q;
  logic [11:0] mrem;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;
  logic [11:0] yr;
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic [3:0]  mon;

  logic [50:0] day_mul;
  logic [25:0] hour_mul;
  logic [19:0] min_mul;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  assign day_mul  = {26'd0, secs[31:7]} * {25'd0, ucd_pkg::DAY_RECIP};
  assign hour_mul = {13'd0, tod[16:4]} * {12'd0, ucd_pkg::HOUR_RECIP};
  assign min_mul  = {10'd0, mrem[11:2]} * {9'd0, ucd_pkg::MIN_RECIP};

  assign leap = (yr[1:0] == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = ucd_pkg::month_days(mon, leap);

  assign stat.year_fits  = (days < {7'd0, ylen});
  assign stat.month_fits = (days < {11'd0, mlen});

  // Each remainder is known to fit its narrow field, so the products and
  // differences are only formed over the low bits.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ucd_pkg::OP_LOAD: begin
        secs   <= epoch_seconds;
        yr     <= ucd_pkg::BASE_YEAR;
        mod100 <= ucd_pkg::BASE_MOD100;
        mod400 <= ucd_pkg::BASE_MOD400;
        mon    <= ucd_pkg::MONTH_JAN;
      end
      ucd_pkg::OP_DAY: begin
        days <= day_mul[50:35];
      end
      ucd_pkg::OP_TOD: begin
        tod <= secs[16:0] - ({1'b0, days} * ucd_pkg::SECS_PER_DAY);
      end
      ucd_pkg::OP_HOUR: begin
        hour_q <= hour_mul[25:21];
      end
      ucd_pkg::OP_HOUR_REM: begin
        mrem <= tod[11:0] - ({7'd0, hour_q} * ucd_pkg::SECS_PER_HOUR);
      end
      ucd_pkg::OP_MIN: begin
        min_q <= min_mul[19:14];
      end
      ucd_pkg::OP_MIN_REM: begin
        sec_q <= mrem[5:0] - (min_q * ucd_pkg::SECS_PER_MIN);
      end
      ucd_pkg::OP_YEAR: begin
        days   <= days - {7'd0, ylen};
        yr     <= yr + 12'd1;
        mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
        mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
      end
      ucd_pkg::OP_MONTH: begin
        days <= days - {11'd0, mlen};
        mon  <= mon + 4'd1;
      end
      ucd_pkg::OP_PUBLISH: begin
        year   <= yr;
        month  <= mon;
        day    <= days[4:0] + 5'd1;
        hour   <= hour_q;
        minute <= min_q;
        second <= sec_q;
      end
      default: begin
      end
    endcase
  end

  a_month_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ucd_pkg::OP_MONTH) |-> (mon < ucd_pkg::MONTH_DEC))
    else $error("month walk ran past December");

  a_year_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ucd_pkg::OP_YEAR) |-> (yr < ucd_pkg::LAST_YEAR))
    else $error("year walk ran past the last representable year");

  a_tod_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ucd_pkg::OP_TOD) |=> (tod < ucd_pkg::SECS_PER_DAY))
    else $error("time of day out of range");

  a_hour_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ucd_pkg::OP_HOUR) |=> (hour_q < 5'd24))
    else $error("hour out of range");

endmodule

[design/ucd_ctrl.sv]
// ----------------------------------------------------------------------------
// ucd_ctrl
// Sequencer for the divisions, the year walk, the month walk and output.
// ----------------------------------------------------------------------------
module ucd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ucd_pkg::ucd_stat_t stat,
  output ucd_pkg::ucd_cmd_t  cmd
);

  ucd_pkg::ucd_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ucd_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ucd_pkg::S_IDLE);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    cmd.op         = ucd_pkg::OP_NONE;
    unique case (state)
      ucd_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ucd_pkg::OP_LOAD;
          state_next = ucd_pkg::S_DAY;
        end
      end
      ucd_pkg::S_DAY: begin
        cmd.op     = ucd_pkg::OP_DAY;
        state_next = ucd_pkg::S_TOD;
      end
      ucd_pkg::S_TOD: begin
        cmd.op     = ucd_pkg::OP_TOD;
        state_next = ucd_pkg::S_HOUR;
      end
      ucd_pkg::S_HOUR: begin
        cmd.op     = ucd_pkg::OP_HOUR;
        state_next = ucd_pkg::S_HOUR_REM;
      end
      ucd_pkg::S_HOUR_REM: begin
        cmd.op     = ucd_pkg::OP_HOUR_REM;
        state_next = ucd_pkg::S_MIN;
      end
      ucd_pkg::S_MIN: begin
        cmd.op     = ucd_pkg::OP_MIN;
        state_next = ucd_pkg::S_MIN_REM;
      end
      ucd_pkg::S_MIN_REM: begin
        cmd.op     = ucd_pkg::OP_MIN_REM;
        state_next = ucd_pkg::S_YEAR;
      end
      ucd_pkg::S_YEAR: begin
        if (stat.year_fits) begin
          state_next = ucd_pkg::S_MONTH;
        end else begin
          cmd.op = ucd_pkg::OP_YEAR;
        end
      end
      ucd_pkg::S_MONTH: begin
        if (stat.month_fits) begin
          state_next = ucd_pkg::S_DONE;
        end else begin
          cmd.op = ucd_pkg::OP_MONTH;
        end
      end
      ucd_pkg::S_DONE: begin
        // The output register may be refilled in the same cycle it is taken.
        if (!out_valid || !out_stall) begin
          cmd.op         = ucd_pkg::OP_PUBLISH;
          out_valid_next = 1'b1;
          state_next     = ucd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ucd_pkg::S_IDLE;
      end
    endcase
  end

  a_publish_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ucd_pkg::S_DONE))
    else $error("result shown without a finished conversion");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ucd_pkg::OP_PUBLISH) |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

[design/unix_seconds_to_civil_date_core.sv]
// ----------------------------------------------------------------------------
// unix_seconds_to_civil_date_core
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 to a Gregorian
// date and time of day.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, epoch_seconds) takes one time value
// per transfer; the output channel (out_valid, out_stall and the six date
// fields) returns one result per input, in order.
// A conversion runs one item at a time. The transfer edge loads the value;
// six steps follow for the divisions by constants (day count, time of day,
// hour, seconds in the hour, minute, second), each a reciprocal multiply or
// a multiply and subtract. The year walk then subtracts one year length per
// elapsed year, the month walk one month length per elapsed month, and a
// final step publishes the result to the output register. The next item can
// be taken on the cycle after publishing. The year walk, one subtraction per
// year, dominates the conversion time.
// in_stall is low only while the core has no conversion in flight. A result
// sits in the output register until taken; the core meanwhile accepts and
// converts the next item, and waits before publishing while out_stall holds.
// Synchronous reset drops out_valid and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module unix_seconds_to_civil_date_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  ucd_pkg::ucd_cmd_t  cmd;
  ucd_pkg::ucd_stat_t stat;

  ucd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ucd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .epoch_seconds (epoch_seconds),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule

[dv/tb_unix_seconds_to_civil_date_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_civil_date_core
// Self-checking bench for the seconds-to-civil-date converter. A queue of
// time values (calendar corner cases first, then random and boundary-heavy
// values) feeds a bursty driver. The output side stalls on its own changing
// pattern. Every returned date is compared field by field against an
// in-bench calendar computation.
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_civil_date_core;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_date_t;

  typedef enum logic [1:0] {
    STALL_NEVER,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_mode_t;

  localparam int RANDOM_ITEMS = 1030;
  localparam int MID_DRAIN_AT = 600;
  localparam int SETTLE_CYCLES = 250;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  logic [31:0] seconds_q[$];
  civil_date_t date_q[$];
  int          n_directed;
  int          n_taken;
  int          n_sent;
  int          n_got;
  int          n_errors;
  int          gap_left;
  int          burst_left;
  stall_mode_t stall_mode;
  int          mode_left;
  logic [7:0]  stall_pat;

  unix_seconds_to_civil_date_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .epoch_seconds (epoch_seconds),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Calendar walk: strip whole days, then whole years from 1970, then months.
  function automatic civil_date_t to_civil_date(input logic [31:0] secs);
    int unsigned days;
    int unsigned tod;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned mon_len[12];
    civil_date_t r;
    mon_len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    days = secs / 32'd86400;
    tod = secs % 32'd86400;
    y = 1970;
    m = 1;
    while (days >= (is_leap_year(y) ? 366 : 365)) begin
      days -= is_leap_year(y) ? 366 : 365;
      y++;
    end
    while (m <= 12) begin
      len = mon_len[m - 1];
      if (m == 2 && is_leap_year(y)) len = 29;
      if (days < len) break;
      days -= len;
      m++;
    end
    r.year = y[11:0];
    r.month = m[3:0];
    r.day = 5'(days + 1);
    r.hour = 5'(tod / 3600);
    r.minute = 6'((tod % 3600) / 60);
    r.second = 6'(tod % 60);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input int idx);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", idx, name, got, want));
  endtask

  // Driver: bursts of transfers separated by random gaps; holds off at the
  // drain marks until every outstanding result has come back.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = $urandom_range(1, 20);
      n_sent = 0;
      n_taken = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) n_sent++;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (seconds_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if ((n_taken == n_directed || n_taken == MID_DRAIN_AT) && n_sent != n_got) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        epoch_seconds <= seconds_q.pop_front();
        n_taken++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Output stall generator: switches between several patterns of its own.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode = STALL_NEVER;
      mode_left = 0;
      stall_pat = 8'h00;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 400);
        stall_pat = 8'($urandom);
      end
      mode_left--;
      case (stall_mode)
        STALL_NEVER: out_stall <= 1'b0;
        STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
        default: begin
          out_stall <= stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
      endcase
    end
  end

  // Result checker and expected-date store.
  always @(posedge clk) begin
    civil_date_t want;
    if (rst) begin
      n_got <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (date_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d-%0d-%0d", year, month, day));
        end else begin
          want = date_q.pop_front();
          check_field("year", int'(year), int'(want.year), n_got);
          check_field("month", int'(month), int'(want.month), n_got);
          check_field("day", int'(day), int'(want.day), n_got);
          check_field("hour", int'(hour), int'(want.hour), n_got);
          check_field("minute", int'(minute), int'(want.minute), n_got);
          check_field("second", int'(second), int'(want.second), n_got);
        end
        n_got <= n_got + 1;
      end
      if (in_valid && !in_stall) date_q.push_back(to_civil_date(epoch_seconds));
    end
  end

  initial begin
    logic [63:0] v;
    int          d;
    n_errors = 0;
    // Epoch, unit boundaries, leap days of 1972 and 2000, the skipped leap
    // day of 2100, the 2038 sign boundary and the last representable second.
    seconds_q = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                  32'd86400, 32'd31535999, 32'd31536000, 32'd68169600, 32'd94694399,
                  32'd94694400, 32'd951782400, 32'd951868799, 32'd951868800,
                  32'd4107542399, 32'd4107542400, 32'h7FFFFFFF, 32'h80000000,
                  32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFE, 32'hFFFFFFFF};
    n_directed = seconds_q.size();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 3))
        0, 1: v = {32'h0, $urandom};
        2: begin
          // Near a midnight, which also lands on month and year edges.
          d = $urandom_range(0, 49709);
          v = 64'(d) * 64'd86400;
          v += ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : $urandom_range(86397, 86399);
        end
        default: v = {32'h0, 32'($urandom_range(0, 200000000))};
      endcase
      seconds_q.push_back(v[31:0]);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (seconds_q.size() == 0 && !in_valid && n_sent == n_got);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0 && date_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
design/ucd_pkg.sv
design/ucd_datapath.sv
design/ucd_ctrl.sv
design/unix_seconds_to_civil_date_core.sv
dv/tb_unix_seconds_to_civil_date_core.sv
